// File: sv/ctt_pkg.sv
package ctt_pkg;

  // Table geometry
  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths fixed by the interface
  localparam int SLOT_FW  = 4;
  localparam int TIMER_W  = 32;
  localparam int WIN_W    = 32;
  localparam int THR_W    = 31;
  localparam int RETRY_W  = 4;
  localparam int IVL_W    = 20;
  localparam int LOAD_W   = 31;
  localparam int SEG_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Register reset values
  localparam logic [IVL_W-1:0]   SCAN_INTERVAL_RST    = IVL_W'(100000);
  localparam logic [LOAD_W-1:0]  TIMEWAIT_TIMEOUT_RST = LOAD_W'(2000000);
  localparam logic [LOAD_W-1:0]  RETRANS_INITIAL_RST  = LOAD_W'(200000);
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST      = RETRY_W'(3);
  localparam logic [SEG_W-1:0]   SEGMENT_SIZE_RST     = SEG_W'(1000);

  // Input action codes
  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_ARM_TW    = 3'd1,
    ACT_ARM_RT    = 3'd2,
    ACT_DISARM_RT = 3'd3,
    ACT_LOAD_WIN  = 3'd4
  } action_e;

  // Result event codes
  typedef enum logic [2:0] {
    EV_IDLE    = 3'd0,
    EV_TWCLOSE = 3'd1,
    EV_RETX    = 3'd2,
    EV_GAVEUP  = 3'd3,
    EV_CUT     = 3'd4
  } ev_kind_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_INTERVAL    = 3'd0,
    REG_TIMEWAIT_TIMEOUT = 3'd1,
    REG_RETRANS_INITIAL  = 3'd2,
    REG_RETRY_LIMIT      = 3'd3,
    REG_SEGMENT_SIZE     = 3'd4
  } cfg_reg_e;

  // Scan controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [SLOT_FW-1:0] slot;
    logic [WIN_W-1:0]   window_value;
    logic               data_pending;
    logic               head_is_new;
  } in_t;

  typedef struct packed {
    logic [SLOT_FW-1:0] event_slot;
    ev_kind_e           event_kind;
    logic [RETRY_W-1:0] retry_number;
    logic [WIN_W-1:0]   new_window;
    logic [THR_W-1:0]   new_threshold;
    logic               last;
  } out_t;

  // Live configuration
  typedef struct packed {
    logic [IVL_W-1:0]   scan_interval;
    logic [LOAD_W-1:0]  timewait_timeout;
    logic [LOAD_W-1:0]  retrans_initial;
    logic [RETRY_W-1:0] retry_limit;
    logic [SEG_W-1:0]   segment_size;
  } cfg_t;

  // Per-connection state held in one cell
  typedef struct packed {
    logic               tw_armed;
    logic [TIMER_W-1:0] tw_left;
    logic               rt_armed;
    logic [TIMER_W-1:0] rt_left;
    logic [RETRY_W-1:0] retry;
    logic               pending;
    logic [WIN_W-1:0]   window;
    logic [THR_W-1:0]   thresh;
  } slot_state_t;

  // Action applied to one selected cell
  typedef struct packed {
    logic              arm_tw;
    logic              arm_rt;
    logic              disarm_rt;
    logic              load_win;
    logic [WIN_W-1:0]  window;
    logic              pending;
    logic              head_new;
    logic [LOAD_W-1:0] tw_load;
    logic [LOAD_W-1:0] rt_load;
  } cell_cmd_t;

endpackage

// File: sv/ctt_cell.sv
module ctt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift_en,
  input  ctt_pkg::slot_state_t shift_in,
  input  logic                sel,
  input  ctt_pkg::cell_cmd_t  cmd,
  output ctt_pkg::slot_state_t state_q
);
  import ctt_pkg::*;

  slot_state_t state_next;

  // Shift from the neighbor during a scan, otherwise apply a selected action
  always_comb begin
    state_next = state_q;
    if (shift_en) begin
      state_next = shift_in;
    end else if (sel) begin
      if (cmd.arm_tw) begin
        state_next.tw_armed = 1'b1;
        state_next.tw_left  = TIMER_W'(cmd.tw_load);
      end
      if (cmd.arm_rt) begin
        state_next.rt_armed = 1'b1;
        state_next.rt_left  = TIMER_W'(cmd.rt_load);
      end
      if (cmd.disarm_rt) begin
        state_next.rt_armed = 1'b0;
      end
      if (cmd.load_win) begin
        state_next.window  = cmd.window;
        state_next.pending = cmd.pending;
        if (cmd.head_new) begin
          state_next.retry = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= '0;
    end else begin
      state_q <= state_next;
    end
  end

endmodule

// File: sv/ctt_step.sv
module ctt_step (
  input  ctt_pkg::cfg_t        cfg,
  input  ctt_pkg::slot_state_t cur,
  input  logic [ctt_pkg::SLOT_FW-1:0] slot_id,
  output ctt_pkg::slot_state_t nxt,
  output logic                 ev_valid,
  output ctt_pkg::out_t        ev
);
  import ctt_pkg::*;

  localparam int BO_W = LOAD_W + (1 << RETRY_W);

  logic [TIMER_W-1:0] ivl;
  logic [TIMER_W-1:0] tw_dec;
  logic [TIMER_W-1:0] rt_dec;
  logic               tw_fire;
  logic               rt_fire;
  logic [RETRY_W-1:0] retry_inc;
  logic [BO_W-1:0]    bo_wide;
  logic [TIMER_W-1:0] bo_val;

  assign ivl = TIMER_W'(cfg.scan_interval);

  // Saturating countdown of both timers
  assign tw_dec  = (cur.tw_left > ivl) ? (cur.tw_left - ivl) : '0;
  assign rt_dec  = (cur.rt_left > ivl) ? (cur.rt_left - ivl) : '0;
  assign tw_fire = cur.tw_armed && (tw_dec == '0);
  assign rt_fire = cur.rt_armed && (rt_dec == '0);

  // Exponential backoff, saturating at all ones
  assign retry_inc = cur.retry + RETRY_W'(1);
  assign bo_wide   = BO_W'(cfg.retrans_initial) << retry_inc;
  assign bo_val    = (|bo_wide[BO_W-1:TIMER_W]) ? '1 : bo_wide[TIMER_W-1:0];

  always_comb begin
    nxt = cur;
    if (cur.tw_armed) begin
      nxt.tw_left = tw_dec;
    end
    if (cur.rt_armed) begin
      nxt.rt_left = rt_dec;
    end
    ev_valid          = tw_fire || rt_fire;
    ev                = '0;
    ev.event_slot     = slot_id;
    ev.event_kind     = EV_IDLE;
    if (tw_fire) begin
      // Time-wait wins over a simultaneous retransmit expiry
      nxt.tw_armed  = 1'b0;
      nxt.rt_armed  = 1'b0;
      nxt.retry     = '0;
      ev.event_kind = EV_TWCLOSE;
    end else if (rt_fire) begin
      nxt.thresh = cur.window[WIN_W-1:1];
      nxt.window = WIN_W'(cfg.segment_size);
      if (!cur.pending) begin
        ev.event_kind = EV_CUT;
      end else if (cur.retry >= cfg.retry_limit) begin
        nxt.rt_armed  = 1'b0;
        ev.event_kind = EV_GAVEUP;
      end else begin
        nxt.retry     = retry_inc;
        nxt.rt_left   = bo_val;
        ev.event_kind = EV_RETX;
      end
      ev.retry_number  = nxt.retry;
      ev.new_window    = nxt.window;
      ev.new_threshold = nxt.thresh;
    end
  end

endmodule

// File: sv/tcp_connection_timer_table_top.sv
// Non-tick actions are applied to the selected cell and produce no result.
// A tick rotates the cell ring once through the update unit, then hands over
// the final result with last set; earlier results of the tick pass through the
// one-deep hold to the output register, and a full output stalls the scan.
// A new input is taken only once the previous tick has handed over its final result.
// Synchronous reset loads the register defaults and clears all slot state.
module tcp_connection_timer_table_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  ctt_pkg::in_t             in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ctt_pkg::out_t            out_data,
  input  logic                     cfg_write,
  input  logic [ctt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ctt_pkg::*;

  cfg_t        cfg;
  state_e      state;
  state_e      state_next;
  logic [SLOT_W-1:0] cnt;
  logic        in_xfer;
  logic        act_xfer;
  logic        out_free;
  logic        step_go;
  logic        load_out;
  out_t        out_next;
  logic        hold_valid;
  out_t        hold_data;
  cell_cmd_t   cmd;
  slot_state_t ring [SLOTS];
  slot_state_t step_nxt;
  logic        ev_valid;
  out_t        ev;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_interval    <= SCAN_INTERVAL_RST;
      cfg.timewait_timeout <= TIMEWAIT_TIMEOUT_RST;
      cfg.retrans_initial  <= RETRANS_INITIAL_RST;
      cfg.retry_limit      <= RETRY_LIMIT_RST;
      cfg.segment_size     <= SEGMENT_SIZE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCAN_INTERVAL:    cfg.scan_interval    <= cfg_data[IVL_W-1:0];
        REG_TIMEWAIT_TIMEOUT: cfg.timewait_timeout <= cfg_data[LOAD_W-1:0];
        REG_RETRANS_INITIAL:  cfg.retrans_initial  <= cfg_data[LOAD_W-1:0];
        REG_RETRY_LIMIT:      cfg.retry_limit      <= cfg_data[RETRY_W-1:0];
        REG_SEGMENT_SIZE:     cfg.segment_size     <= cfg_data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign act_xfer = in_xfer && (in_data.action != ACT_TICK);
  assign out_free = !out_valid || out_ready;

  // Decode a non-tick action for the selected cell
  always_comb begin
    cmd           = '0;
    cmd.window    = in_data.window_value;
    cmd.pending   = in_data.data_pending;
    cmd.head_new  = in_data.head_is_new;
    cmd.tw_load   = cfg.timewait_timeout;
    cmd.rt_load   = cfg.retrans_initial;
    case (in_data.action)
      ACT_ARM_TW:    cmd.arm_tw    = 1'b1;
      ACT_ARM_RT:    cmd.arm_rt    = 1'b1;
      ACT_DISARM_RT: cmd.disarm_rt = 1'b1;
      ACT_LOAD_WIN:  cmd.load_win  = 1'b1;
      default: ;
    endcase
  end

  // Ring of cells; slot 0 sits at the head and feeds the update unit
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    slot_state_t shift_in;
    if (i == SLOTS - 1) begin : g_tail
      assign shift_in = step_nxt;
    end else begin : g_body
      assign shift_in = ring[i+1];
    end
    ctt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (step_go),
      .shift_in (shift_in),
      .sel      (act_xfer && (int'(in_data.slot) == i)),
      .cmd      (cmd),
      .state_q  (ring[i])
    );
  end

  ctt_step u_step (
    .cfg      (cfg),
    .cur      (ring[0]),
    .slot_id  (SLOT_FW'(cnt)),
    .nxt      (step_nxt),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  // Scan controller: a slot advances unless its event finds both buffers full
  always_comb begin
    state_next = state;
    step_go    = 1'b0;
    load_out   = 1'b0;
    out_next   = hold_data;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && (in_data.action == ACT_TICK)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        step_go  = !ev_valid || !hold_valid || out_free;
        load_out = step_go && ev_valid && hold_valid;
        if (step_go && (cnt == SLOT_W'(SLOTS - 1))) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        load_out = out_free;
        if (!hold_valid) begin
          out_next            = '0;
          out_next.event_kind = EV_IDLE;
        end
        out_next.last = 1'b1;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (step_go) begin
        cnt <= (cnt == SLOT_W'(SLOTS - 1)) ? '0 : cnt + SLOT_W'(1);
      end
    end
  end

  // One-deep hold so the final result of a tick can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (step_go && ev_valid) begin
      hold_valid <= 1'b1;
    end else if (state == ST_FLUSH && out_free) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && ev_valid) begin
      hold_data <= ev;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_next;
    end
  end

  // Checks
  a_idle_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_kind == EV_IDLE) |-> out_data.last)
    else $error("idle result without last");

  a_hold_in_tick: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (state != ST_IDLE))
    else $error("held result outside a tick");

  a_ring_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cnt == '0))
    else $error("cell ring not realigned after tick");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_data) && out_valid))
    else $error("output overwritten while stalled");

endmodule
